/* rtl/core/i2cram_pkg.sv */
// Package: shared types, phase codes and item kinds for the I2C register access master.
`default_nettype none

package i2cram_pkg;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] CFG_HALF_BIT  = 2'd1;
  localparam logic [1:0] CFG_START_STOP = 2'd2;
  localparam logic [1:0] CFG_ACK_TMO   = 2'd3;

  // Configuration reset values
  localparam logic [6:0] DEV_ADDR_RST   = 7'd104;
  localparam logic [7:0] HALF_BIT_RST   = 8'd2;
  localparam logic [7:0] START_STOP_RST = 8'd4;
  localparam logic [7:0] ACK_TMO_RST    = 8'd250;

  // Sequencer phases; send phases are SEND + stage*4 + sub
  localparam logic [4:0] PH_IDLE       = 5'd0;
  localparam logic [4:0] PH_START_SETUP = 5'd1;
  localparam logic [4:0] PH_START_HOLD = 5'd2;
  localparam logic [4:0] PH_RS_LOW     = 5'd3;
  localparam logic [4:0] PH_RS_SETUP   = 5'd4;
  localparam logic [4:0] PH_RS_HOLD    = 5'd5;
  localparam logic [4:0] PH_RD_LOW     = 5'd6;
  localparam logic [4:0] PH_RD_HIGH    = 5'd7;
  localparam logic [4:0] PH_NACK_LOW   = 5'd8;
  localparam logic [4:0] PH_NACK_HIGH  = 5'd9;
  localparam logic [4:0] PH_STOP_LOW   = 5'd10;
  localparam logic [4:0] PH_STOP_SETUP = 5'd11;
  localparam logic [4:0] PH_STOP_FREE  = 5'd12;
  localparam logic [4:0] PH_SEND_ADDR_W = 5'd16;
  localparam logic [4:0] PH_SEND_REG   = 5'd20;
  localparam logic [4:0] PH_SEND_DATA  = 5'd24;
  localparam logic [4:0] PH_SEND_ADDR_R = 5'd28;

  // Send stages
  localparam logic [1:0] STG_ADDR_W = 2'd0;
  localparam logic [1:0] STG_REG    = 2'd1;
  localparam logic [1:0] STG_DATA   = 2'd2;
  localparam logic [1:0] STG_ADDR_R = 2'd3;

  // Send sub-phases
  localparam logic [1:0] SUB_LOW      = 2'd0;
  localparam logic [1:0] SUB_HIGH     = 2'd1;
  localparam logic [1:0] SUB_ACK_LOW  = 2'd2;
  localparam logic [1:0] SUB_ACK_WAIT = 2'd3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] half_bit;
    logic [7:0] start_stop;
    logic [7:0] ack_tmo;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_error;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/i2cram_if.sv */
// Interfaces: command/tick input channel and bus-level result channel.
`default_nettype none

interface i2cram_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, kind, reg_addr, write_data, sda_in, input ready);
  modport sink (input valid, kind, reg_addr, write_data, sda_in, output ready);
endinterface

interface i2cram_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       nack_error;

  modport source (output valid, scl_level, sda_low, busy_res, done_res, read_data,
                  nack_error, input ready);
  modport sink (input valid, scl_level, sda_low, busy_res, done_res, read_data,
                nack_error, output ready);
endinterface

`default_nettype wire

/* rtl/core/i2cram_cfg.sv */
// Configuration registers: slave address and bus timing.
`default_nettype none

module i2cram_cfg
  import i2cram_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output cfg_t            cfg
);

  cfg_t cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr   <= DEV_ADDR_RST;
      cfg_r.half_bit   <= HALF_BIT_RST;
      cfg_r.start_stop <= START_STOP_RST;
      cfg_r.ack_tmo    <= ACK_TMO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEV_ADDR:   cfg_r.dev_addr   <= cfg_wdata[6:0];
        CFG_HALF_BIT:   cfg_r.half_bit   <= cfg_wdata;
        CFG_START_STOP: cfg_r.start_stop <= cfg_wdata;
        CFG_ACK_TMO:    cfg_r.ack_tmo    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/i2cram_seq.sv */
// Bus sequencer: transaction state and the one-step update for each item.
`default_nettype none

module i2cram_seq
  import i2cram_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output res_t       res
);

  logic [4:0] phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [7:0] saved_reg_r, saved_reg_nxt;
  logic [7:0] saved_data_r, saved_data_nxt;
  logic       is_write_r, is_write_nxt;
  logic [7:0] last_read_r, last_read_nxt;
  logic       err_r, err_nxt;
  logic       done;

  logic [7:0] tick_inc;
  logic       el_h, el_s;
  logic [3:0] bit_inc;
  logic [7:0] rd_shift;
  logic [1:0] stage, sub;

  // Phase timing: a phase ends when its count reaches the duration (zero acts as one)
  assign tick_inc = tick_r + 8'd1;
  assign el_h     = (tick_inc >= cfg.half_bit) || (tick_inc == 8'd0);
  assign el_s     = (tick_inc >= cfg.start_stop) || (tick_inc == 8'd0);
  assign bit_inc  = bit_cnt_r + 4'd1;
  assign rd_shift = (tick_r == 8'd0) ? {shift_r[6:0], item.sda_in} : shift_r;
  assign stage    = phase_r[3:2];
  assign sub      = phase_r[1:0];

  // Next state for one item
  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    tick_nxt       = tick_r;
    wait_nxt       = wait_r;
    saved_reg_nxt  = saved_reg_r;
    saved_data_nxt = saved_data_r;
    is_write_nxt   = is_write_r;
    last_read_nxt  = last_read_r;
    err_nxt        = err_r;
    done           = 1'b0;

    if (item.kind == KIND_TICK) begin
      if (phase_r[4]) begin
        // Byte send: low half, high half, ACK low half, ACK wait
        unique case (sub)
          SUB_LOW: begin
            tick_nxt = el_h ? 8'd0 : tick_inc;
            if (el_h) phase_nxt = phase_r + 5'd1;
          end
          SUB_HIGH: begin
            tick_nxt = el_h ? 8'd0 : tick_inc;
            if (el_h) begin
              shift_nxt   = {shift_r[6:0], 1'b0};
              bit_cnt_nxt = bit_inc;
              if (bit_inc >= BITS_PER_BYTE) begin
                phase_nxt = phase_r + 5'd1;
                wait_nxt  = 8'd0;
              end else begin
                phase_nxt = phase_r - 5'd1;
              end
            end
          end
          SUB_ACK_LOW: begin
            tick_nxt = el_h ? 8'd0 : tick_inc;
            if (el_h) begin
              phase_nxt = phase_r + 5'd1;
              wait_nxt  = 8'd0;
            end
          end
          default: begin
            if (!item.sda_in) begin
              // ACK seen: move on to the next part of the transaction
              tick_nxt = 8'd0;
              unique case (stage)
                STG_ADDR_W: begin
                  phase_nxt   = PH_SEND_REG;
                  shift_nxt   = saved_reg_r;
                  bit_cnt_nxt = 4'd0;
                end
                STG_REG: begin
                  if (is_write_r) begin
                    phase_nxt   = PH_SEND_DATA;
                    shift_nxt   = saved_data_r;
                    bit_cnt_nxt = 4'd0;
                  end else begin
                    phase_nxt = PH_RS_LOW;
                  end
                end
                STG_DATA: phase_nxt = PH_STOP_LOW;
                default: begin
                  phase_nxt   = PH_RD_LOW;
                  bit_cnt_nxt = 4'd0;
                  shift_nxt   = 8'd0;
                end
              endcase
            end else if (wait_r >= cfg.ack_tmo) begin
              // ACK timeout: abort with stop
              err_nxt   = 1'b1;
              phase_nxt = PH_STOP_LOW;
              tick_nxt  = 8'd0;
            end else begin
              wait_nxt = wait_r + 8'd1;
            end
          end
        endcase
      end else begin
        unique case (phase_r)
          PH_START_SETUP: begin
            tick_nxt = el_s ? 8'd0 : tick_inc;
            if (el_s) phase_nxt = PH_START_HOLD;
          end
          PH_START_HOLD: begin
            tick_nxt = el_s ? 8'd0 : tick_inc;
            if (el_s) begin
              phase_nxt   = PH_SEND_ADDR_W;
              shift_nxt   = {cfg.dev_addr, 1'b0};
              bit_cnt_nxt = 4'd0;
            end
          end
          PH_RS_LOW: begin
            tick_nxt = el_h ? 8'd0 : tick_inc;
            if (el_h) phase_nxt = PH_RS_SETUP;
          end
          PH_RS_SETUP: begin
            tick_nxt = el_s ? 8'd0 : tick_inc;
            if (el_s) phase_nxt = PH_RS_HOLD;
          end
          PH_RS_HOLD: begin
            tick_nxt = el_s ? 8'd0 : tick_inc;
            if (el_s) begin
              phase_nxt   = PH_SEND_ADDR_R;
              shift_nxt   = {cfg.dev_addr, 1'b1};
              bit_cnt_nxt = 4'd0;
            end
          end
          PH_RD_LOW: begin
            tick_nxt = el_h ? 8'd0 : tick_inc;
            if (el_h) phase_nxt = PH_RD_HIGH;
          end
          PH_RD_HIGH: begin
            // sample SDA on the first tick of the high half
            shift_nxt = rd_shift;
            tick_nxt  = el_h ? 8'd0 : tick_inc;
            if (el_h) begin
              bit_cnt_nxt = bit_inc;
              if (bit_inc >= BITS_PER_BYTE) begin
                last_read_nxt = rd_shift;
                phase_nxt     = PH_NACK_LOW;
              end else begin
                phase_nxt = PH_RD_LOW;
              end
            end
          end
          PH_NACK_LOW: begin
            tick_nxt = el_h ? 8'd0 : tick_inc;
            if (el_h) phase_nxt = PH_NACK_HIGH;
          end
          PH_NACK_HIGH: begin
            tick_nxt = el_h ? 8'd0 : tick_inc;
            if (el_h) phase_nxt = PH_STOP_LOW;
          end
          PH_STOP_LOW: begin
            tick_nxt = el_s ? 8'd0 : tick_inc;
            if (el_s) phase_nxt = PH_STOP_SETUP;
          end
          PH_STOP_SETUP: begin
            tick_nxt = el_s ? 8'd0 : tick_inc;
            if (el_s) phase_nxt = PH_STOP_FREE;
          end
          PH_STOP_FREE: begin
            tick_nxt = el_s ? 8'd0 : tick_inc;
            if (el_s) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
          end
          default: begin
            // idle and unused codes
            phase_nxt = PH_IDLE;
            tick_nxt  = 8'd0;
          end
        endcase
      end
    end else if ((item.kind == KIND_READ || item.kind == KIND_WRITE) &&
                 phase_r == PH_IDLE) begin
      // New command, taken only when idle
      saved_reg_nxt  = item.reg_addr;
      saved_data_nxt = item.write_data;
      is_write_nxt   = (item.kind == KIND_WRITE);
      err_nxt        = 1'b0;
      phase_nxt      = PH_START_SETUP;
      tick_nxt       = 8'd0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_cnt_r    <= 4'd0;
      shift_r      <= 8'd0;
      tick_r       <= 8'd0;
      wait_r       <= 8'd0;
      saved_reg_r  <= 8'd0;
      saved_data_r <= 8'd0;
      is_write_r   <= 1'b0;
      last_read_r  <= 8'd0;
      err_r        <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      tick_r       <= tick_nxt;
      wait_r       <= wait_nxt;
      saved_reg_r  <= saved_reg_nxt;
      saved_data_r <= saved_data_nxt;
      is_write_r   <= is_write_nxt;
      last_read_r  <= last_read_nxt;
      err_r        <= err_nxt;
    end
  end

  // Bus levels of the phase reached after this item
  always_comb begin
    res.scl_level  = 1'b1;
    res.sda_low    = 1'b0;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.done_res   = done;
    res.read_data  = last_read_nxt;
    res.nack_error = err_nxt;
    if (phase_nxt[4]) begin
      res.scl_level = phase_nxt[0];
      res.sda_low   = !phase_nxt[1] && !shift_nxt[7];
    end else begin
      unique case (phase_nxt)
        PH_START_HOLD, PH_RS_HOLD, PH_STOP_SETUP: res.sda_low = 1'b1;
        PH_RS_LOW, PH_RD_LOW, PH_NACK_LOW:        res.scl_level = 1'b0;
        PH_STOP_LOW: begin
          res.scl_level = 1'b0;
          res.sda_low   = 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/i2c_register_access_master.sv */
// Data path: an item enters the input register when accepted and moves to the result register
// when that register is empty or being drained, where its result is offered; the sequencer
// state advances as the item enters the result register.
// Throughput: one item per cycle while the result side keeps taking items; the
// sequencer state update is the only loop.
// Reset (synchronous, rst_n low): sequencer to idle with all state zero, configuration
// to its defaults, both registers empty. No clearing pass.
`default_nettype none

module i2c_register_access_master
  import i2cram_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  i2cram_in_if.sink       in_ch,
  i2cram_out_if.source    out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  cfg_t  cfg;
  item_t in_item_r;
  logic  in_valid_r;
  res_t  step_res;
  res_t  out_res_r;
  logic  out_valid_r;
  logic  advance;

  // An item moves to the result register when that register is empty or being drained
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  i2cram_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.kind       <= in_ch.kind;
      in_item_r.reg_addr   <= in_ch.reg_addr;
      in_item_r.write_data <= in_ch.write_data;
      in_item_r.sda_in     <= in_ch.sda_in;
    end
  end

  i2cram_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_level  = out_res_r.scl_level;
  assign out_ch.sda_low    = out_res_r.sda_low;
  assign out_ch.busy_res   = out_res_r.busy_res;
  assign out_ch.done_res   = out_res_r.done_res;
  assign out_ch.read_data  = out_res_r.read_data;
  assign out_ch.nack_error = out_res_r.nack_error;

endmodule

`default_nettype wire

/* rtl/core/i2cram_checker.sv */
// Port-level checker for the I2C register access master, bound to the top level.
`default_nettype none

module i2cram_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       scl_level,
  input wire logic       sda_low,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [7:0] read_data,
  input wire logic       nack_error
);

  // No result is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A finished transaction leaves the bus idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res && scl_level && !sda_low)
    else $error("done reported while bus not idle");

  // Idle bus: SCL high and SDA released
  a_idle_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> scl_level && !sda_low)
    else $error("bus driven while idle");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(nack_error)
      && $stable(busy_res) && $stable(done_res))
    else $error("stalled result changed");

endmodule

bind i2c_register_access_master i2cram_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .scl_level  (out_ch.scl_level),
  .sda_low    (out_ch.sda_low),
  .busy_res   (out_ch.busy_res),
  .done_res   (out_ch.done_res),
  .read_data  (out_ch.read_data),
  .nack_error (out_ch.nack_error)
);

`default_nettype wire
